FILE: sv/uop_issue_queue_with_throttle_macros.svh
// assertion macros for the micro-op issue queue
// no dependencies; taken in by the top level with an include
`ifndef UOP_ISSUE_QUEUE_WITH_THROTTLE_MACROS_SVH
`define UOP_ISSUE_QUEUE_WITH_THROTTLE_MACROS_SVH

`ifndef SYNTHESIS

`define UIQ_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("uiq check failed");

`define UIQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uiq check failed");

`define UIQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uiq check failed");

`else

`define UIQ_ASSERT_ALWAYS(lbl, clk, rst, cond)

`define UIQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define UIQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/uiq_pkg.sv
// shared types and constants for the micro-op issue queue
// no dependencies
`default_nettype none

package uiq_pkg;

   localparam int TAG_W          = 16;
   localparam int BID_W          = 16;
   localparam int LAT_W          = 3;
   localparam int PEND_W         = 6;
   localparam int OCC_W          = 6;
   localparam int GAP_W          = 8;
   localparam int RSV_W          = 5;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 8;
   localparam int REQ_TDATA_W    = 64;
   localparam int RSP_TDATA_W    = 48;
   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_BID_BITS   = 16;

   localparam logic [GAP_W-1:0] GAP_MAX         = '1;
   localparam logic [GAP_W-1:0] MIN_GAP_RESET   = 8'd2;
   localparam logic [RSV_W-1:0] RESERVE_RESET   = 5'd4;

   typedef enum logic {
      OP_CYCLE = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PERFECT = 2'd0,
      CSR_MIN_GAP = 2'd1,
      CSR_RESERVE = 2'd2
   } csr_idx_type;

   // request payload, lowest field last
   typedef struct packed {
      logic [4:0]        pad;
      logic [PEND_W-1:0] pending_count;
      logic [BID_W-1:0]  flush_bid;
      logic              alloc_is_colsum;
      logic [LAT_W-1:0]  alloc_latency;
      logic [BID_W-1:0]  alloc_bid;
      logic [TAG_W-1:0]  alloc_tag;
      logic              alloc_valid;
   } req_item_type;

   // result payload, lowest field last
   typedef struct packed {
      logic [5:0]       pad;
      logic [OCC_W-1:0] occupancy;
      logic             stall_res;
      logic             alloc_accepted;
      logic             colsum_blocked;
      logic [BID_W-1:0] issue_bid;
      logic [TAG_W-1:0] issue_tag;
      logic             issue_valid;
   } rsp_item_type;

   // oldest ready entry offered by the slot array
   typedef struct packed {
      logic             found;
      logic             colsum;
      logic [TAG_W-1:0] tag;
      logic [BID_W-1:0] bid;
   } head_type;

   // throttle decision
   typedef struct packed {
      logic take;
      logic blocked;
   } issue_type;

endpackage

`default_nettype wire

FILE: sv/uiq_entries.sv
// slot array with age matrix: allocation, latency count-down, oldest-ready pick, flush
// depends on uiq_pkg
`default_nettype none

module uiq_entries
   import uiq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int BID_BITS    = DEF_BID_BITS,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cycle_en,
   input  wire logic              flush_en,
   input  wire req_item_type      item,
   input  wire logic              take,
   output head_type               head,
   output logic                   alloc_ok,
   output logic [CNT_W-1:0]       occ_next
);

   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [QUEUE_DEPTH-1:0] colsum_ff;
   logic [TAG_W-1:0]       tag_ff   [QUEUE_DEPTH];
   logic [BID_W-1:0]       bid_ff   [QUEUE_DEPTH];
   logic [LAT_W-1:0]       rem_ff   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] older_ff [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0] free_vec, free_oh, alloc_oh;
   logic [QUEUE_DEPTH-1:0] valid_a, rdy, sel, fdrop, idrop, colsum_a;
   logic [LAT_W-1:0]       rem_a    [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] older_a  [QUEUE_DEPTH];
   logic [TAG_W-1:0]       tag_a    [QUEUE_DEPTH];
   logic [BID_W-1:0]       bid_a    [QUEUE_DEPTH];
   logic [LAT_W-1:0]       new_rem;
   logic [BID_BITS-1:0]    flush_id;
   logic [BID_BITS-1:0]    bid_diff [QUEUE_DEPTH];

   assign free_vec = ~valid_ff;
   assign free_oh  = free_vec & (~free_vec + QUEUE_DEPTH'(1));
   assign alloc_ok = cycle_en && item.alloc_valid && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign alloc_oh = alloc_ok ? free_oh : '0;
   assign new_rem  = (item.alloc_latency == '0) ? '0 : item.alloc_latency - LAT_W'(1);
   assign flush_id = BID_BITS'(item.flush_bid);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid_a[i]  = valid_ff[i] | alloc_oh[i];
         colsum_a[i] = alloc_oh[i] ? item.alloc_is_colsum : colsum_ff[i];
         tag_a[i]    = alloc_oh[i] ? item.alloc_tag : tag_ff[i];
         bid_a[i]    = alloc_oh[i] ? item.alloc_bid : bid_ff[i];
         if (alloc_oh[i]) begin
            rem_a[i] = new_rem;
         end else if (rem_ff[i] == '0) begin
            rem_a[i] = '0;
         end else begin
            rem_a[i] = rem_ff[i] - LAT_W'(1);
         end
         // new entry is younger than every live one; its column is cleared elsewhere
         older_a[i] = alloc_oh[i] ? valid_ff : (older_ff[i] & ~alloc_oh);
         rdy[i]     = valid_a[i] && (rem_a[i] == '0);
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel[i]      = rdy[i] && ((older_a[i] & rdy) == '0);
         bid_diff[i] = BID_BITS'(bid_ff[i]) - flush_id;
         fdrop[i]    = valid_ff[i] && !bid_diff[i][BID_BITS-1];
      end
   end

   always_comb begin
      head = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         head.found  = head.found | sel[i];
         head.colsum = head.colsum | (sel[i] & colsum_a[i]);
         head.tag    = head.tag | (sel[i] ? tag_a[i] : '0);
         head.bid    = head.bid | (sel[i] ? bid_a[i] : '0);
      end
   end

   assign idrop = take ? sel : '0;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (flush_en) begin
         valid_in = valid_ff & ~fdrop;
         count_in = CNT_W'($countones(valid_ff & ~fdrop));
      end else if (cycle_en) begin
         valid_in = valid_a & ~idrop;
         count_in = count_ff + CNT_W'(alloc_ok) - CNT_W'(take);
      end
   end

   assign occ_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cycle_en) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            rem_ff[i]    <= rem_a[i];
            older_ff[i]  <= older_a[i];
            colsum_ff[i] <= colsum_a[i];
            tag_ff[i]    <= tag_a[i];
            bid_ff[i]    <= bid_a[i];
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/uiq_throttle.sv
// column-sum issue throttle: cycle requests since last column-sum issue and hold decision
// depends on uiq_pkg
`default_nettype none

module uiq_throttle
   import uiq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cycle_en,
   input  wire head_type         head,
   input  wire logic             perfect,
   input  wire logic [GAP_W-1:0] min_gap,
   output issue_type             issue
);

   logic [GAP_W-1:0] gap_ff, gap_in, gap_inc;
   logic             seen_ff, seen_in;
   logic             checked;

   assign gap_inc       = (gap_ff == GAP_MAX) ? gap_ff : gap_ff + GAP_W'(1);
   assign checked       = head.colsum && !perfect;
   assign issue.blocked = head.found && checked && seen_ff && (gap_inc < min_gap);
   assign issue.take    = head.found && !issue.blocked;

   always_comb begin
      gap_in  = gap_ff;
      seen_in = seen_ff;
      if (cycle_en) begin
         if (issue.take && checked) begin
            gap_in  = '0;
            seen_in = 1'b1;
         end else begin
            gap_in  = gap_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         gap_ff  <= gap_in;
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/uop_issue_queue_with_throttle.sv
// Age-ordered micro-op issue queue with column-sum issue throttle. One request is
// taken per clock while req_tready is high: allocation, latency count-down,
// oldest-ready selection, the throttle decision and flush all settle in the cycle
// of the transfer, and the result appears on rsp in the following cycle from an
// output register. req_tready stays high while that register is empty or being
// drained, so a sustained rate of one item per cycle holds while rsp_tready is
// high. No clearing pass after reset: the slot valid bits clear at once.
// Depends on uiq_pkg, uiq_entries, uiq_throttle and the macros header.
`include "uop_issue_queue_with_throttle_macros.svh"
`default_nettype none

module uop_issue_queue_with_throttle
   import uiq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int BID_BITS    = DEF_BID_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // alloc_valid, alloc_tag, alloc_bid, alloc_latency, alloc_is_colsum,
   // flush_bid, pending_count, zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // op
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // issue_valid, issue_tag, issue_bid, colsum_blocked, alloc_accepted,
   // stall_res, occupancy, zero fill
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = ((CNT_W > PEND_W) ? CNT_W : PEND_W) + 1;

   logic             perfect_ff, perfect_in;
   logic [GAP_W-1:0] min_gap_ff, min_gap_in;
   logic [RSV_W-1:0] reserve_ff, reserve_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   req_item_type     item;
   logic             accept, cycle_en, flush_en;
   head_type         head;
   issue_type        issue;
   logic             alloc_ok, issued;
   logic [CNT_W-1:0] occ_next;
   logic [SUM_W-1:0] thr, load;

   // configuration
   always_comb begin
      perfect_in = perfect_ff;
      min_gap_in = min_gap_ff;
      reserve_in = reserve_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_PERFECT: perfect_in = csr_wdata[0];
            CSR_MIN_GAP: min_gap_in = csr_wdata[GAP_W-1:0];
            CSR_RESERVE: reserve_in = csr_wdata[RSV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perfect_ff <= 1'b0;
         min_gap_ff <= MIN_GAP_RESET;
         reserve_ff <= RESERVE_RESET;
      end else begin
         perfect_ff <= perfect_in;
         min_gap_ff <= min_gap_in;
         reserve_ff <= reserve_in;
      end
   end

   // request transfer
   assign item       = req_item_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cycle_en   = accept && (op_type'(req_tuser) == OP_CYCLE);
   assign flush_en   = accept && (op_type'(req_tuser) == OP_FLUSH);

   uiq_entries #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .BID_BITS    (BID_BITS)
   ) u_entries (
      .clock    (clock),
      .reset    (reset),
      .cycle_en (cycle_en),
      .flush_en (flush_en),
      .item     (item),
      .take     (issue.take),
      .head     (head),
      .alloc_ok (alloc_ok),
      .occ_next (occ_next)
   );

   uiq_throttle u_throttle (
      .clock    (clock),
      .reset    (reset),
      .cycle_en (cycle_en),
      .head     (head),
      .perfect  (perfect_ff),
      .min_gap  (min_gap_ff),
      .issue    (issue)
   );

   // stall threshold
   assign thr  = (SUM_W'(reserve_ff) >= SUM_W'(QUEUE_DEPTH)) ? '0
               : SUM_W'(QUEUE_DEPTH) - SUM_W'(reserve_ff);
   assign load = SUM_W'(occ_next) + SUM_W'(item.pending_count);

   assign issued = cycle_en && issue.take;

   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.issue_valid    = issued;
      rsp_data_in.issue_tag      = issued ? head.tag : '0;
      rsp_data_in.issue_bid      = issued ? head.bid : '0;
      rsp_data_in.colsum_blocked = cycle_en && issue.blocked;
      rsp_data_in.alloc_accepted = alloc_ok;
      rsp_data_in.stall_res      = load > thr;
      rsp_data_in.occupancy      = OCC_W'(occ_next);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   `UIQ_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_next <= CNT_W'(QUEUE_DEPTH))
   `UIQ_ASSERT_IMPLY(a_issue_or_block, clock, reset, rsp_valid_ff, !(rsp_data_ff.issue_valid && rsp_data_ff.colsum_blocked))
   `UIQ_ASSERT_NEXT(a_flush_quiet, clock, reset, flush_en, !rsp_data_ff.issue_valid && !rsp_data_ff.alloc_accepted)

endmodule

`default_nettype wire
